/* src/dwsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwsi_pkg
// Shared types, constants and saturating sign-magnitude helpers of the
// double-well split-step integrator.
// ----------------------------------------------------------------------------
package dwsi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;

	localparam logic [63:0] MAXI    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [64:0] MAXI_P1 = 65'h0_8000_0000_0000_0000;

	localparam logic signed [63:0] W_HI = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] W_LO = -W_HI - 64'sd1;

	// request codes
	localparam logic [2:0] REQ_LOAD      = 3'd0;
	localparam logic [2:0] REQ_DRIFT_XY  = 3'd1;
	localparam logic [2:0] REQ_DRIFT_X   = 3'd2;
	localparam logic [2:0] REQ_DRIFT_Y   = 3'd3;
	localparam logic [2:0] REQ_KICK_BOTH = 3'd4;
	localparam logic [2:0] REQ_KICK_X    = 3'd5;
	localparam logic [2:0] REQ_KICK_Y    = 3'd6;

	// register indexes
	localparam logic [2:0] REG_TIME_STEP  = 3'd0;
	localparam logic [2:0] REG_MASS_X     = 3'd1;
	localparam logic [2:0] REG_MASS_Y     = 3'd2;
	localparam logic [2:0] REG_WELL_DEPTH = 3'd3;
	localparam logic [2:0] REG_WELL_HALF  = 3'd4;
	localparam logic [2:0] REG_Y_FREQ     = 3'd5;
	localparam logic [2:0] REG_COUPLING   = 3'd6;

	typedef enum logic {
		UNIT_MUL,
		UNIT_DIV
	} unit_mode_t;

	typedef struct packed {
		logic       start;
		unit_mode_t mode;
	} unit_cmd_t;

	typedef struct packed {
		logic signed [63:0] v;
		logic               sat;
	} sval_t;

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic sval_t make_val(input logic neg, input logic [64:0] m);
		sval_t       r;
		logic [63:0] mm;
		if (m > {1'b0, MAXI}) begin
			mm    = MAXI;
			r.sat = 1'b1;
		end else begin
			mm    = m[63:0];
			r.sat = 1'b0;
		end
		r.v = neg ? 64'(-mm) : mm;
		return r;
	endfunction

	function automatic sval_t sadd(input logic signed [63:0] a, input logic signed [63:0] b);
		logic [63:0] ma;
		logic [63:0] mb;
		sval_t       r;
		ma = mag(a);
		mb = mag(b);
		if (a[63] == b[63]) r = make_val(a[63], {1'b0, ma} + {1'b0, mb});
		else if (ma >= mb) r = make_val(a[63], {1'b0, ma - mb});
		else r = make_val(b[63], {1'b0, mb - ma});
		return r;
	endfunction

	// rescale a 128-bit magnitude product, dt/2 folds in one extra bit
	function automatic sval_t fmul_post(input logic [127:0] p, input logic extra,
			input logic neg);
		logic [127:0] s;
		sval_t        r;
		s = extra ? (p >> (FRAC_BITS + 1)) : (p >> FRAC_BITS);
		if (s[127:64] != 64'd0) r = make_val(neg, MAXI_P1);
		else r = make_val(neg, {1'b0, s[63:0]});
		return r;
	endfunction

	function automatic sval_t clampw(input logic signed [63:0] v);
		sval_t r;
		r.sat = 1'b0;
		r.v   = v;
		if (v > W_HI) begin
			r.v   = W_HI;
			r.sat = 1'b1;
		end else if (v < W_LO) begin
			r.v   = W_LO;
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/dwsi_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwsi channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface dwsi_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic signed [31:0] load_pos_x;
	logic signed [31:0] load_pos_y;
	logic signed [31:0] load_mom_x;
	logic signed [31:0] load_mom_y;

	modport source (output valid, req_type, load_pos_x, load_pos_y, load_mom_x,
		load_mom_y, input ready);
	modport sink (input valid, req_type, load_pos_x, load_pos_y, load_mom_x,
		load_mom_y, output ready);
endinterface

interface dwsi_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] mom_x;
	logic signed [31:0] mom_y;
	logic               overflow;

	modport source (output valid, pos_x, pos_y, mom_x, mom_y, overflow, input ready);
	modport sink (input valid, pos_x, pos_y, mom_x, mom_y, overflow, output ready);
endinterface

interface dwsi_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/dwsi_serial_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwsi_serial_unit
// Shared bit-serial 64x64 multiplier and 128/64 restoring divider.
// ----------------------------------------------------------------------------
module dwsi_serial_unit (
	input  wire               clk,
	input  wire               arst_n,
	input  wire dwsi_pkg::unit_cmd_t cmd,
	input  wire  [63:0]       a,
	input  wire  [63:0]       b,
	input  wire  [63:0]       num_hi,
	input  wire  [63:0]       num_lo,
	input  wire  [63:0]       den,
	output logic              done,
	output logic [63:0]       hi,
	output logic [63:0]       lo
);

	logic [63:0]      r_q;
	logic [63:0]      l_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	dwsi_pkg::unit_mode_t mode_q;

	logic [64:0] msum;
	logic [63:0] rs;
	logic        ge;

	always_comb begin
		msum = {1'b0, r_q} + (l_q[0] ? {1'b0, a} : 65'd0);
		rs   = {r_q[62:0], l_q[63]};
		ge   = r_q[63] || (rs >= den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= dwsi_pkg::UNIT_MUL;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				mode_q <= cmd.mode;
				if (cmd.mode == dwsi_pkg::UNIT_DIV) begin
					r_q <= num_hi;
					l_q <= num_lo;
				end else begin
					r_q <= '0;
					l_q <= b;
				end
			end else if (busy_q) begin
				if (mode_q == dwsi_pkg::UNIT_DIV) begin
					// quotient bits shift in where the dividend shifts out
					r_q <= ge ? (rs - den) : rs;
					l_q <= {l_q[62:0], ge};
				end else begin
					{r_q, l_q} <= {msum, l_q[63:1]};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign hi   = r_q;
	assign lo   = l_q;

endmodule
`default_nettype wire

/* src/double_well_split_step_integrator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_well_split_step_integrator
// Split-step operators on one 2-D particle in a coupled double well.
// ----------------------------------------------------------------------------
// One request is taken at a time. Load and the unused code go straight to
// the output stage. Every other operator is a fixed sequence of multiplies
// and divides on one shared bit-serial unit, each result written back once
// the unit is done: a drift of one axis is two operations, a kick of px
// eight, a kick of py five, and a kick of both thirteen. A divide by zero
// or one that overflows is resolved without running the unit. The finished
// state sits in an output register, so a new request is taken while the
// previous result waits.
// ----------------------------------------------------------------------------
module double_well_split_step_integrator (
	input wire         clk,
	input wire         arst_n,
	dwsi_req_if.sink   req,
	dwsi_rsp_if.source rsp,
	dwsi_cfg_if.sink   cfg
);

	typedef enum logic [4:0] {
		S_IDLE, S_FIN,
		K_X2, K_A2, K_A4, K_U4, K_DIV, K_MD, K_LY, K_KX,
		Y_W2, Y_K, Y_KY, Y_LX, Y_KK,
		D_XM, D_XD, D_YM, D_YD
	} state_t;

	state_t state_q;
	state_t nxt;
	logic   busy_q;
	logic   sat_q;
	logic   neg_q;
	logic [2:0] req_q;

	logic [30:0]        dt_q, mx_q, my_q, dep_q, aw_q, w_q;
	logic signed [31:0] lam_q;

	logic signed [dwsi_pkg::WORD_BITS-1:0] pos_x_q, pos_y_q, mom_x_q, mom_y_q;
	logic signed [63:0] t_a_q, t_b_q, t_c_q;

	logic signed [31:0] rsp_px_q, rsp_py_q, rsp_mx_q, rsp_my_q;
	logic               rsp_ov_q, rsp_valid_q;

	logic signed [63:0] px64, py64, mx64, my64;
	logic signed [63:0] a_op, b_op, acc_sel;
	logic               is_div, extra, neg_c, triv, wb_en, step, sat_any;
	logic [63:0]        num_hi, num_lo, den, fm;

	dwsi_pkg::sval_t   unit_res, triv_res, wb_res, diff_r, add_r, clamp_r;
	dwsi_pkg::sval_t   ld_px, ld_py, ld_mx, ld_my;
	dwsi_pkg::unit_cmd_t cmd;
	logic              u_done;
	logic [63:0]       u_hi, u_lo;

	assign px64 = 64'(pos_x_q);
	assign py64 = 64'(pos_y_q);
	assign mx64 = 64'(mom_x_q);
	assign my64 = 64'(mom_y_q);

	assign step = (state_q != S_IDLE) && (state_q != S_FIN);

	always_comb begin
		a_op   = '0;
		b_op   = '0;
		is_div = 1'b0;
		extra  = 1'b0;
		num_hi = '0;
		num_lo = '0;
		den    = '0;
		fm     = dwsi_pkg::mag(t_b_q);
		unique case (state_q)
			K_X2: begin a_op = px64; b_op = px64; end
			K_A2: begin a_op = 64'(aw_q); b_op = 64'(aw_q); end
			K_A4: begin a_op = t_b_q; b_op = t_b_q; end
			K_U4: begin a_op = {31'd0, dep_q, 2'b00}; b_op = px64; end
			K_DIV: begin
				is_div = 1'b1;
				num_hi = fm >> (64 - dwsi_pkg::FRAC_BITS);
				num_lo = fm << dwsi_pkg::FRAC_BITS;
				den    = dwsi_pkg::mag(t_c_q);
			end
			K_MD: begin a_op = t_b_q; b_op = t_a_q; end
			K_LY: begin a_op = 64'(lam_q); b_op = py64; end
			K_KX: begin a_op = 64'(dt_q); b_op = t_c_q; extra = 1'b1; end
			Y_W2: begin a_op = 64'(w_q); b_op = 64'(w_q); end
			Y_K: begin a_op = 64'(my_q); b_op = t_a_q; end
			Y_KY: begin a_op = t_a_q; b_op = py64; end
			Y_LX: begin a_op = 64'(lam_q); b_op = px64; end
			Y_KK: begin a_op = 64'(dt_q); b_op = t_c_q; extra = 1'b1; end
			D_XM: begin a_op = 64'(dt_q); b_op = mx64; end
			D_XD: begin
				is_div = 1'b1;
				num_hi = u_hi;
				num_lo = u_lo;
				den    = (req_q == dwsi_pkg::REQ_DRIFT_X) ? {33'd0, mx_q} : {32'd0, mx_q, 1'b0};
			end
			D_YM: begin a_op = 64'(dt_q); b_op = my64; end
			D_YD: begin
				is_div = 1'b1;
				num_hi = u_hi;
				num_lo = u_lo;
				den    = {32'd0, my_q, 1'b0};
			end
			default: ;
		endcase
		unique case (state_q)
			K_DIV: neg_c = t_b_q[63] ^ t_c_q[63];
			D_XD: neg_c = mom_x_q[dwsi_pkg::WORD_BITS-1];
			D_YD: neg_c = mom_y_q[dwsi_pkg::WORD_BITS-1];
			default: neg_c = a_op[63] ^ b_op[63];
		endcase
	end

	always_comb begin
		triv = is_div && ((den == 64'd0) || (num_hi >= den));
		if ((den == 64'd0) && (num_hi == 64'd0) && (num_lo == 64'd0)) begin
			triv_res = '{v: 64'sd0, sat: 1'b0};
		end else begin
			triv_res = dwsi_pkg::make_val(neg_c, dwsi_pkg::MAXI_P1);
		end
		if (is_div) unit_res = dwsi_pkg::make_val(neg_q, {1'b0, u_lo});
		else unit_res = dwsi_pkg::fmul_post({u_hi, u_lo}, extra, neg_q);
		wb_res = busy_q ? unit_res : triv_res;
		wb_en  = step && ((busy_q && u_done) || (!busy_q && triv));
		cmd.start = step && !busy_q && !triv;
		cmd.mode  = is_div ? dwsi_pkg::UNIT_DIV : dwsi_pkg::UNIT_MUL;
	end

	always_comb begin
		unique case (state_q)
			K_KX: acc_sel = mx64;
			Y_KK: acc_sel = my64;
			D_XD: acc_sel = px64;
			D_YD: acc_sel = py64;
			default: acc_sel = t_a_q;
		endcase
		diff_r  = dwsi_pkg::sadd(t_a_q, -t_b_q);
		add_r   = dwsi_pkg::sadd(acc_sel, wb_res.v);
		clamp_r = dwsi_pkg::clampw(add_r.v);
		ld_px   = dwsi_pkg::clampw(64'(req.load_pos_x));
		ld_py   = dwsi_pkg::clampw(64'(req.load_pos_y));
		ld_mx   = dwsi_pkg::clampw(64'(req.load_mom_x));
		ld_my   = dwsi_pkg::clampw(64'(req.load_mom_y));
	end

	always_comb begin
		nxt     = state_q;
		sat_any = wb_res.sat;
		unique case (state_q)
			K_X2: nxt = K_A2;
			K_A2: nxt = K_A4;
			K_A4: begin nxt = K_U4; sat_any = wb_res.sat | diff_r.sat; end
			K_U4: nxt = K_DIV;
			K_DIV: nxt = K_MD;
			K_MD: nxt = K_LY;
			K_LY: begin nxt = K_KX; sat_any = wb_res.sat | add_r.sat; end
			K_KX: begin
				nxt     = (req_q == dwsi_pkg::REQ_KICK_BOTH) ? Y_W2 : S_FIN;
				sat_any = wb_res.sat | add_r.sat | clamp_r.sat;
			end
			Y_W2: nxt = Y_K;
			Y_K: nxt = Y_KY;
			Y_KY: nxt = Y_LX;
			Y_LX: begin nxt = Y_KK; sat_any = wb_res.sat | add_r.sat; end
			Y_KK: begin nxt = S_FIN; sat_any = wb_res.sat | add_r.sat | clamp_r.sat; end
			// raw product feeds the divide, nothing rescaled here
			D_XM: begin nxt = D_XD; sat_any = 1'b0; end
			D_XD: begin
				nxt     = (req_q == dwsi_pkg::REQ_DRIFT_XY) ? D_YM : S_FIN;
				sat_any = wb_res.sat | add_r.sat | clamp_r.sat;
			end
			D_YM: begin nxt = D_YD; sat_any = 1'b0; end
			D_YD: begin nxt = S_FIN; sat_any = wb_res.sat | add_r.sat | clamp_r.sat; end
			default: sat_any = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= 1'b0;
			sat_q       <= 1'b0;
			neg_q       <= 1'b0;
			req_q       <= '0;
			rsp_valid_q <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			mom_x_q     <= '0;
			mom_y_q     <= '0;
			dt_q        <= 31'd655;
			mx_q        <= 31'd65536;
			my_q        <= 31'd65536;
			dep_q       <= 31'd327680;
			aw_q        <= 31'd65536;
			w_q         <= 31'd65536;
			lam_q       <= 32'sd188613;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					dwsi_pkg::REG_TIME_STEP: dt_q <= cfg.data[30:0];
					dwsi_pkg::REG_MASS_X: mx_q <= cfg.data[30:0];
					dwsi_pkg::REG_MASS_Y: my_q <= cfg.data[30:0];
					dwsi_pkg::REG_WELL_DEPTH: dep_q <= cfg.data[30:0];
					dwsi_pkg::REG_WELL_HALF: aw_q <= cfg.data[30:0];
					dwsi_pkg::REG_Y_FREQ: w_q <= cfg.data[30:0];
					dwsi_pkg::REG_COUPLING: lam_q <= cfg.data;
					default: ;
				endcase
			end
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				neg_q  <= neg_c;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q <= req.req_type;
						sat_q <= 1'b0;
						unique case (req.req_type)
							dwsi_pkg::REQ_LOAD: begin
								pos_x_q <= dwsi_pkg::WORD_BITS'(ld_px.v);
								pos_y_q <= dwsi_pkg::WORD_BITS'(ld_py.v);
								mom_x_q <= dwsi_pkg::WORD_BITS'(ld_mx.v);
								mom_y_q <= dwsi_pkg::WORD_BITS'(ld_my.v);
								sat_q   <= ld_px.sat | ld_py.sat | ld_mx.sat | ld_my.sat;
								state_q <= S_FIN;
							end
							dwsi_pkg::REQ_DRIFT_XY, dwsi_pkg::REQ_DRIFT_X: state_q <= D_XM;
							dwsi_pkg::REQ_DRIFT_Y: state_q <= D_YM;
							dwsi_pkg::REQ_KICK_BOTH, dwsi_pkg::REQ_KICK_X: state_q <= K_X2;
							dwsi_pkg::REQ_KICK_Y: state_q <= Y_W2;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_px_q    <= 32'(pos_x_q);
						rsp_py_q    <= 32'(pos_y_q);
						rsp_mx_q    <= 32'(mom_x_q);
						rsp_my_q    <= 32'(mom_y_q);
						rsp_ov_q    <= sat_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					if (wb_en) begin
						busy_q  <= 1'b0;
						sat_q   <= sat_q | sat_any;
						state_q <= nxt;
						unique case (state_q)
							K_X2, K_MD, Y_W2, Y_K, Y_KY: t_a_q <= wb_res.v;
							K_A2, K_U4, K_DIV: t_b_q <= wb_res.v;
							K_A4: begin
								t_c_q <= wb_res.v;
								t_a_q <= diff_r.v;
							end
							K_LY, Y_LX: t_c_q <= -add_r.v;
							K_KX: mom_x_q <= dwsi_pkg::WORD_BITS'(clamp_r.v);
							Y_KK: mom_y_q <= dwsi_pkg::WORD_BITS'(clamp_r.v);
							D_XD: pos_x_q <= dwsi_pkg::WORD_BITS'(clamp_r.v);
							D_YD: pos_y_q <= dwsi_pkg::WORD_BITS'(clamp_r.v);
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	dwsi_serial_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.a      (dwsi_pkg::mag(a_op)),
		.b      (dwsi_pkg::mag(b_op)),
		.num_hi (num_hi),
		.num_lo (num_lo),
		.den    (den),
		.done   (u_done),
		.hi     (u_hi),
		.lo     (u_lo)
	);

	assign req.ready    = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.pos_x    = rsp_px_q;
	assign rsp.pos_y    = rsp_py_q;
	assign rsp.mom_x    = rsp_mx_q;
	assign rsp.mom_y    = rsp_my_q;
	assign rsp.overflow = rsp_ov_q;

endmodule
`default_nettype wire
